FILE: hdl/slr_pkg.sv
// Package for the slope line rasterizer: coordinate width and payload structs.
// No dependencies.
`timescale 1ns / 1ps
package slr_pkg;
  localparam int COORD_BITS = 6;
  localparam int COLOR_BITS = 24;

  typedef struct packed {
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic [COLOR_BITS-1:0] color;
  } seg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  last_pixel;
  } pix_t;
endpackage

FILE: hdl/slope_line_rasterizer_top.sv
// Top level of the slope line rasterizer: segment sequencer and pixel pipeline.
// Depends on slr_pkg.
//
//   channel | valid     | stall     | payload
//   seg     | seg_valid | seg_stall | seg   (slr_pkg::seg_t)
//   pix     | pix_valid | pix_stall | pix   (slr_pkg::pix_t)
//
// Each segment is first latched into the setup registers; the step sequencer then
// issues one pixel index per cycle, while the output is not stalled, into a five-stage
// pipeline (offset, product, numerator, upper quotient bits, lower quotient bits).
// The next segment is taken once the last index of the current one has been issued.
// Reset clears the sequencer and all pipeline valid bits.
// A stall at the output freezes the whole pipeline and the sequencer.
`timescale 1ns / 1ps
module slope_line_rasterizer_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           seg_valid,
  output logic           seg_stall,
  input  slr_pkg::seg_t  seg,
  output logic           pix_valid,
  input  logic           pix_stall,
  output slr_pkg::pix_t  pix
);
  localparam int CB = slr_pkg::COORD_BITS;
  localparam int CL = slr_pkg::COLOR_BITS;
  // Signed widths needed: offsets/deltas CB+1, numerator up to 2*CB+3; each has one spare bit.
  localparam int DW = CB + 2;
  localparam int NW = 2 * CB + 4;
  // Quotient bits below QL are resolved in the last stage.
  localparam int QL = CB / 2;

  logic adv;
  assign adv = !(pix_valid && pix_stall);

  // Segment setup registers.
  logic                busy;
  logic                stepy;     // step coordinate is y
  logic                flat;      // fixed other coordinate (no rounding)
  logic [CB-1:0]       vcur;
  logic [CB-1:0]       vend;      // last value to issue
  logic signed [DW-1:0] base;     // other coordinate start
  logic signed [DW-1:0] org;      // step coordinate start
  logic signed [DW-1:0] num;      // delta of other coordinate
  logic signed [DW-1:0] den;      // delta of step coordinate, made positive
  logic [CL-1:0]       col;

  assign seg_stall = busy || !adv;

  // Decode of the incoming segment.
  logic signed [DW-1:0] dx, dy, adx, ady;
  logic [CB-1:0] sx, ex, sy, ey;
  always_comb begin
    dx  = DW'(seg.x_end) - DW'(seg.x_start);
    dy  = DW'(seg.y_end) - DW'(seg.y_start);
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    sx  = seg.x_start < seg.x_end ? seg.x_start : seg.x_end;
    ex  = seg.x_start < seg.x_end ? seg.x_end : seg.x_start;
    sy  = seg.y_start < seg.y_end ? seg.y_start : seg.y_end;
    ey  = seg.y_start < seg.y_end ? seg.y_end : seg.y_start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (adv) begin
      if (!busy && seg_valid) begin
        busy <= 1'b1;
        col  <= seg.color;
        if (dx == 0 && dy == 0) begin
          stepy <= 1'b0; flat <= 1'b1;
          vcur <= seg.x_start; vend <= seg.x_start;
          base <= DW'(seg.y_start);
        end else if (dx == 0 || (dy != 0 && !(ady < adx))) begin
          stepy <= 1'b1; flat <= (dx == 0);
          vcur <= sy; vend <= ey - 1'b1;
          base <= DW'(seg.x_start); org <= DW'(seg.y_start);
          num  <= dy < 0 ? -dx : dx; den <= ady;
        end else begin
          stepy <= 1'b0; flat <= (dy == 0);
          vcur <= sx; vend <= ex - 1'b1;
          base <= DW'(seg.y_start); org <= DW'(seg.x_start);
          num  <= dx < 0 ? -dy : dy; den <= adx;
        end
      end else if (busy) begin
        if (vcur == vend) busy <= 1'b0;
        vcur <= vcur + 1'b1;
      end
    end
  end

  // Stage 1: offset t = v - org.
  logic s1_v, s2_v, s3_v, s4_v, s5_v;
  logic s1_last, s2_last, s3_last, s4_last, s5_last;
  logic s1_y, s2_y, s3_y, s4_y, s5_y;
  logic s1_f, s2_f, s3_f, s4_f;
  logic [CB-1:0] s1_s, s2_s, s3_s, s4_s, s5_s;
  logic [CB-1:0] s1_b, s2_b, s3_b, s4_b, s5_o;
  logic [CL-1:0] s1_c, s2_c, s3_c, s4_c, s5_c;
  logic signed [DW-1:0] s1_t, s1_n, s1_d, s2_d, s2_bs;
  logic signed [NW-1:0] s2_p, s3_n2;
  logic [NW-1:0] s3_d2, s4_d2, s4_rem;
  logic [CB-1:0] s4_q;

  // Numerator is nonnegative in range (rounded coordinate lies in [0, 2^CB)),
  // so the quotient comes from a restoring divide split over two stages.
  logic [NW-1:0] rem_hi, rem_lo;
  logic [CB-1:0] quo_hi, quo_lo;
  always_comb begin
    rem_hi = s3_n2[NW-1] ? '0 : $unsigned(s3_n2);
    quo_hi = '0;
    for (int i = CB - 1; i >= QL; i--) begin
      if (rem_hi >= (s3_d2 << i)) begin
        rem_hi = rem_hi - (s3_d2 << i);
        quo_hi[i] = 1'b1;
      end
    end
  end

  always_comb begin
    rem_lo = s4_rem;
    quo_lo = s4_q;
    for (int i = QL - 1; i >= 0; i--) begin
      if (rem_lo >= (s4_d2 << i)) begin
        rem_lo = rem_lo - (s4_d2 << i);
        quo_lo[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0; s2_v <= 1'b0; s3_v <= 1'b0; s4_v <= 1'b0; s5_v <= 1'b0;
    end else if (adv) begin
      s1_v <= busy; s2_v <= s1_v; s3_v <= s2_v; s4_v <= s3_v; s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last <= vcur == vend; s1_y <= stepy; s1_f <= flat; s1_s <= vcur;
      s1_b <= base[CB-1:0]; s1_c <= col;
      s1_t <= DW'(vcur) - org; s1_n <= num; s1_d <= den;
      // Stage 2: product num*t.
      s2_last <= s1_last; s2_y <= s1_y; s2_f <= s1_f; s2_s <= s1_s;
      s2_b <= s1_b; s2_c <= s1_c; s2_d <= s1_d;
      s2_bs <= DW'(s1_b);
      s2_p <= NW'(s1_n) * NW'(s1_t);
      // Stage 3: 2*(base*den + num*t) + den, with divisor 2*den.
      s3_last <= s2_last; s3_y <= s2_y; s3_f <= s2_f; s3_s <= s2_s;
      s3_b <= s2_b; s3_c <= s2_c;
      s3_n2 <= ((NW'(s2_bs) * NW'(s2_d) + s2_p) <<< 1) + NW'(s2_d);
      s3_d2 <= NW'(s2_d) << 1;
      // Stage 4: upper quotient bits.
      s4_last <= s3_last; s4_y <= s3_y; s4_f <= s3_f; s4_s <= s3_s;
      s4_b <= s3_b; s4_c <= s3_c;
      s4_rem <= rem_hi; s4_q <= quo_hi; s4_d2 <= s3_d2;
      // Stage 5: lower quotient bits and output select.
      s5_last <= s4_last; s5_y <= s4_y; s5_s <= s4_s; s5_c <= s4_c;
      s5_o <= s4_f ? s4_b : quo_lo;
    end
  end

  assign pix_valid        = s5_v;
  assign pix.pixel_x      = s5_y ? s5_o : s5_s;
  assign pix.pixel_y      = s5_y ? s5_s : s5_o;
  assign pix.pixel_color  = s5_c;
  assign pix.last_pixel   = s5_last;

`ifndef SYNTHESIS
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> seg_stall) else $error("segment taken while busy");
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && pix_stall) |=> $stable(pix)) else $error("output moved in stall");
  a_issue: assert property (@(posedge clk) disable iff (rst)
    (busy && adv && vcur != vend) |=> busy) else $error("segment ended early");
`endif
endmodule
